// File: src/lrq_pkg.sv
// Package for the load ready qualifier: widths, codes, state encoding and the
// configuration register record. Every other file of the block but lrq_ram uses it.
package lrq_pkg;

  localparam int WINDOW_DEPTH = 8;

  localparam int SAMPLE_W   = 24;
  localparam int TICK_W     = 32;
  localparam int AVG_W      = 28;
  localparam int DIST_W     = 8;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int DV_W       = SUM_W + 4;
  localparam int DCNT_W     = $clog2(DV_W);
  localparam int FILL_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_WAITING = 2'd1,
    EVT_READY   = 2'd2
  } evt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_HOLD_TIME       = 3'd1,
    REG_READY_TIMEOUT   = 3'd2,
    REG_LOAD_THRESHOLD  = 3'd3,
    REG_READY_MIN       = 3'd4,
    REG_DISTURB_DIFF    = 3'd5,
    REG_DISTURB_LIMIT   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0]        sample_interval_ms;
    logic [31:0]        hold_time_ms;
    logic [31:0]        ready_timeout_ms;
    logic signed [23:0] load_threshold_g;
    logic signed [23:0] ready_min_g;
    logic [22:0]        disturb_diff_g;
    logic [7:0]         disturb_limit;
  } cfg_t;

endpackage

// File: src/lrq_if.sv
// Channel interfaces of the load ready qualifier: input items, result items and
// configuration writes. Widths come from lrq_pkg.
interface lrq_in_if;
  import lrq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [TICK_W-1:0]          now_ms;
  logic signed [SAMPLE_W-1:0] mass_g;
  modport source (output valid, operation, now_ms, mass_g, input ready);
  modport sink (input valid, operation, now_ms, mass_g, output ready);
endinterface

interface lrq_out_if;
  import lrq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    ready_res;
  logic                    sample_taken;
  logic [1:0]              indicator_event;
  logic signed [AVG_W-1:0] average_q4;
  modport source (output valid, ready_res, sample_taken, indicator_event, average_q4,
                  input ready);
  modport sink (input valid, ready_res, sample_taken, indicator_event, average_q4,
                output ready);
endinterface

interface lrq_cfg_if;
  import lrq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/load_ready_qualifier.sv
// Load ready qualifier top level: sequencer, window bookkeeping and ready latch.
// A taken update passes through ST_DECODE, ST_READ, ST_PREP, ST_DIV and ST_DECIDE
// to ST_DONE, with the average formed by the bit-serial divider in ST_DIV; other
// items go from ST_DECODE to ST_DONE. A new item is accepted only once the result
// of the last is loaded and the sequencer is back in ST_IDLE; a stalled result holds it.
// Synchronous active-low reset clears the sequencer, window and latch state and restores register defaults.
module load_ready_qualifier (
  input  logic      clk,
  input  logic      rst_n,
  lrq_in_if.sink    in_ch,
  lrq_out_if.source out_ch,
  lrq_cfg_if.sink   cfg_ch
);
  import lrq_pkg::*;

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic [1:0]                 op_r;
  logic [TICK_W-1:0]          now_r;
  logic signed [SAMPLE_W-1:0] w_r;
  logic                       neg_r, neg_nxt;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic signed [AVG_W-1:0] prev_r, prev_nxt;
  logic                    hold_run_r, hold_run_nxt;
  logic [TICK_W-1:0]       hold_start_r, hold_start_nxt;
  logic                    latch_r, latch_nxt;
  logic                    ann_r, ann_nxt;
  logic [DIST_W-1:0]       dist_r, dist_nxt;
  logic [TICK_W-1:0]       last_r, last_nxt;
  logic [TICK_W-1:0]       since_r, since_nxt;
  evt_t                    evt_r, evt_nxt;
  logic                    taken_r, taken_nxt;

  logic                    out_valid_r;
  logic                    out_load;
  logic                    res_ready_r;
  logic                    res_taken_r;
  evt_t                    res_evt_r;
  logic signed [AVG_W-1:0] res_avg_r;

  logic                       ram_re;
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] old_s;

  logic              div_start;
  logic              div_done;
  logic [DV_W-1:0]   div_dividend;
  logic [DV_W-1:0]   quo;
  logic [DV_W-1:0]   num;
  logic [DV_W-1:0]   mag;

  logic [AVG_W-1:0]        avg_mag;
  logic signed [AVG_W-1:0] avg_s;
  logic signed [AVG_W:0]   diff_s;
  logic [AVG_W:0]          abs_diff;
  logic                    low_avg;
  logic                    big_change;
  logic                    heavy;
  logic [TICK_W-1:0]       hold_ref;
  logic                    hold_ok;
  logic                    interval_ok;
  logic                    expired;
  logic [DIST_W-1:0]       dist_inc;
  logic                    drop;
  logic signed [AVG_W-1:0] drop_avg;

  lrq_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .cfg   (cfg)
  );

  lrq_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(w_r),
    .re   (ram_re),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  lrq_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (fill_r),
    .done    (div_done),
    .quotient(quo)
  );

  // Entries beyond the fill count were never written since the last clear.
  assign old_s = (fill_r == FILL_W'(WINDOW_DEPTH)) ? $signed(ram_rdata) : '0;

  assign num          = {sum_r, 4'b0000};
  assign mag          = sum_r[SUM_W-1] ? (~num + 1'b1) : num;
  assign div_dividend = mag + DV_W'(fill_r >> 1);

  assign avg_mag    = quo[AVG_W-1:0];
  assign avg_s      = neg_r ? $signed(~avg_mag + 1'b1) : $signed(avg_mag);
  assign diff_s     = {avg_s[AVG_W-1], avg_s} - {prev_r[AVG_W-1], prev_r};
  assign abs_diff   = diff_s[AVG_W] ? $unsigned(~diff_s + 1'b1) : $unsigned(diff_s);
  assign low_avg    = avg_s < $signed({cfg.ready_min_g, 4'b0000});
  assign big_change = abs_diff >= {2'b00, cfg.disturb_diff_g, 4'b0000};
  assign heavy      = w_r > cfg.load_threshold_g;
  assign hold_ref   = hold_run_r ? hold_start_r : now_r;
  assign hold_ok    = (now_r - hold_ref) >= cfg.hold_time_ms;
  assign interval_ok = (now_r - last_r) >= TICK_W'(cfg.sample_interval_ms);
  assign expired    = latch_r && ((now_r - since_r) >= cfg.ready_timeout_ms);
  assign dist_inc   = (dist_r < cfg.disturb_limit) ? dist_r + 1'b1 : dist_r;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    sum_nxt        = sum_r;
    slot_nxt       = slot_r;
    fill_nxt       = fill_r;
    prev_nxt       = prev_r;
    hold_run_nxt   = hold_run_r;
    hold_start_nxt = hold_start_r;
    latch_nxt      = latch_r;
    ann_nxt        = ann_r;
    dist_nxt       = dist_r;
    last_nxt       = last_r;
    since_nxt      = since_r;
    evt_nxt        = evt_r;
    taken_nxt      = taken_r;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    drop           = 1'b0;
    drop_avg       = avg_s;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        evt_nxt   = EVT_NONE;
        taken_nxt = 1'b0;
        state_nxt = ST_DONE;
        case (op_r)
          OP_UPDATE: begin
            if (interval_ok) begin
              taken_nxt = 1'b1;
              last_nxt  = now_r;
              ram_re    = 1'b1;
              state_nxt = ST_READ;
            end
          end
          OP_QUERY: begin
            if (expired) begin
              drop     = 1'b1;
              drop_avg = prev_r;
            end
          end
          OP_CLEAR: begin
            sum_nxt        = '0;
            slot_nxt       = '0;
            fill_nxt       = '0;
            prev_nxt       = '0;
            hold_run_nxt   = 1'b0;
            hold_start_nxt = '0;
            latch_nxt      = 1'b0;
            ann_nxt        = 1'b0;
            dist_nxt       = '0;
            last_nxt       = '0;
            since_nxt      = '0;
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        ram_we   = 1'b1;
        sum_nxt  = sum_r + SUM_W'(w_r) - SUM_W'(old_s);
        slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (fill_r != FILL_W'(WINDOW_DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        neg_nxt   = sum_r[SUM_W-1];
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        prev_nxt = avg_s;
        if (latch_r) begin
          if (expired) begin
            drop = 1'b1;
          end else if (low_avg || big_change) begin
            dist_nxt = dist_inc;
            if (dist_inc >= cfg.disturb_limit) begin
              drop = 1'b1;
            end
          end else begin
            dist_nxt = '0;
          end
        end else if (heavy) begin
          if (!hold_run_r) begin
            hold_run_nxt   = 1'b1;
            hold_start_nxt = now_r;
          end
          if (hold_ok) begin
            latch_nxt = 1'b1;
            since_nxt = now_r;
            dist_nxt  = '0;
            ann_nxt   = 1'b1;
            evt_nxt   = EVT_READY;
          end
        end else begin
          drop = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (drop) begin
      prev_nxt       = drop_avg;
      hold_run_nxt   = 1'b0;
      hold_start_nxt = '0;
      latch_nxt      = 1'b0;
      ann_nxt        = 1'b0;
      dist_nxt       = '0;
      since_nxt      = '0;
      evt_nxt        = EVT_WAITING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sum_r        <= '0;
      slot_r       <= '0;
      fill_r       <= '0;
      prev_r       <= '0;
      hold_run_r   <= 1'b0;
      hold_start_r <= '0;
      latch_r      <= 1'b0;
      ann_r        <= 1'b0;
      dist_r       <= '0;
      last_r       <= '0;
      since_r      <= '0;
      evt_r        <= EVT_NONE;
      taken_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      slot_r       <= slot_nxt;
      fill_r       <= fill_nxt;
      prev_r       <= prev_nxt;
      hold_run_r   <= hold_run_nxt;
      hold_start_r <= hold_start_nxt;
      latch_r      <= latch_nxt;
      ann_r        <= ann_nxt;
      dist_r       <= dist_nxt;
      last_r       <= last_nxt;
      since_r      <= since_nxt;
      evt_r        <= evt_nxt;
      taken_r      <= taken_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    if (state_r == ST_IDLE && in_ch.valid) begin
      op_r  <= in_ch.operation;
      now_r <= in_ch.now_ms;
      w_r   <= in_ch.mass_g;
    end
    if (out_load) begin
      res_ready_r <= latch_r;
      res_taken_r <= taken_r;
      res_evt_r   <= evt_r;
      res_avg_r   <= prev_r;
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.ready_res       = res_ready_r;
  assign out_ch.sample_taken    = res_taken_r;
  assign out_ch.indicator_event = res_evt_r;
  assign out_ch.average_q4      = res_avg_r;

endmodule

// File: src/lrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the sample window of the load ready qualifier; no dependencies.
module lrq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/lrq_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, DV_W quotient bits in all.
// Divides the rounded window sum magnitude by the fill count; uses lrq_pkg.
module lrq_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lrq_pkg::DV_W-1:0]  dividend,
  input  logic [lrq_pkg::FILL_W-1:0] divisor,
  output logic                      done,
  output logic [lrq_pkg::DV_W-1:0]  quotient
);
  import lrq_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DV_W-1:0]   quo_r;
  logic [FILL_W-1:0] rem_r;
  logic [FILL_W-1:0] dsr_r;
  logic [FILL_W:0]   rem_shift;
  logic [FILL_W:0]   rem_sub;
  logic              take;

  assign rem_shift = {rem_r, quo_r[DV_W-1]};
  assign take      = rem_shift >= {1'b0, dsr_r};
  assign rem_sub   = rem_shift - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DV_W-2:0], take};
      rem_r <= take ? rem_sub[FILL_W-1:0] : rem_shift[FILL_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/lrq_cfg.sv
// Configuration register file of the load ready qualifier.
// Takes writes from the configuration channel; uses lrq_pkg and lrq_cfg_if.
module lrq_cfg (
  input  logic          clk,
  input  logic          rst_n,
  lrq_cfg_if.sink       cfg_ch,
  output lrq_pkg::cfg_t cfg
);
  import lrq_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_interval_ms <= 16'd50;
      cfg_r.hold_time_ms       <= 32'd1000;
      cfg_r.ready_timeout_ms   <= 32'd30000;
      cfg_r.load_threshold_g   <= 24'sd100;
      cfg_r.ready_min_g        <= 24'sd50;
      cfg_r.disturb_diff_g     <= 23'd20;
      cfg_r.disturb_limit      <= 8'd3;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_SAMPLE_INTERVAL: cfg_r.sample_interval_ms <= cfg_ch.data[15:0];
        REG_HOLD_TIME:       cfg_r.hold_time_ms       <= cfg_ch.data;
        REG_READY_TIMEOUT:   cfg_r.ready_timeout_ms   <= cfg_ch.data;
        REG_LOAD_THRESHOLD:  cfg_r.load_threshold_g   <= $signed(cfg_ch.data[23:0]);
        REG_READY_MIN:       cfg_r.ready_min_g        <= $signed(cfg_ch.data[23:0]);
        REG_DISTURB_DIFF:    cfg_r.disturb_diff_g     <= cfg_ch.data[22:0];
        REG_DISTURB_LIMIT:   cfg_r.disturb_limit      <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: dv/lrq_checker.sv
// Checker for the load ready qualifier: watches the input, result and register write
// channels, predicts every result item and compares it with what the block returns.
// Depends on lrq_pkg and the channel interfaces in lrq_if.sv.
module lrq_checker (
  input  logic clk,
  input  logic rst_n,
  lrq_in_if    in_ch,
  lrq_out_if   out_ch,
  lrq_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrq_pkg::*;

  typedef struct packed {
    logic             ready_res;
    logic             sample_taken;
    logic [1:0]       indicator_event;
    logic [AVG_W-1:0] average_q4;
  } result_t;

  result_t pending_results[$];

  cfg_t                       regs;
  logic signed [SAMPLE_W-1:0] win [WINDOW_DEPTH];
  longint                     win_sum;
  longint                     prev_avg;
  int unsigned                slot;
  int unsigned                fill;
  bit                         hold_on;
  bit                         latched;
  bit                         announced;
  logic [31:0]                hold_tick;
  logic [31:0]                last_tick;
  logic [31:0]                since_tick;
  int unsigned                dist_run;

  function automatic void restore_state();
    foreach (win[i]) win[i] = '0;
    win_sum    = 0;
    prev_avg   = 0;
    slot       = 0;
    fill       = 0;
    hold_on    = 1'b0;
    latched    = 1'b0;
    announced  = 1'b0;
    hold_tick  = '0;
    last_tick  = '0;
    since_tick = '0;
    dist_run   = 0;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SAMPLE_INTERVAL: regs.sample_interval_ms = data[15:0];
      REG_HOLD_TIME:       regs.hold_time_ms = data;
      REG_READY_TIMEOUT:   regs.ready_timeout_ms = data;
      REG_LOAD_THRESHOLD:  regs.load_threshold_g = data[23:0];
      REG_READY_MIN:       regs.ready_min_g = data[23:0];
      REG_DISTURB_DIFF:    regs.disturb_diff_g = data[22:0];
      REG_DISTURB_LIMIT:   regs.disturb_limit = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic longint push_average(logic signed [SAMPLE_W-1:0] w);
    longint num;
    longint mag;
    longint q;
    win_sum = win_sum + longint'(w) - longint'(win[slot]);
    win[slot] = w;
    slot = (slot + 1) % WINDOW_DEPTH;
    if (fill < WINDOW_DEPTH) fill++;
    num = win_sum * 16;
    mag = (num < 0) ? -num : num;
    q = (mag + longint'(fill / 2)) / longint'(fill);
    return (num < 0) ? -q : q;
  endfunction

  function automatic void drop_latch(longint avg);
    prev_avg   = avg;
    hold_on    = 1'b0;
    hold_tick  = '0;
    latched    = 1'b0;
    announced  = 1'b0;
    dist_run   = 0;
    since_tick = '0;
  endfunction

  function automatic bit timed_out(logic [31:0] now);
    logic [31:0] held;
    held = now - since_tick;
    return latched && (held >= regs.ready_timeout_ms);
  endfunction

  function automatic result_t qualify_item(logic [1:0] op, logic [31:0] now,
                                           logic signed [SAMPLE_W-1:0] w);
    result_t     res;
    evt_t        ev;
    bit          taken;
    longint      avg;
    longint      diff;
    longint      min16;
    longint      diff16;
    int          thr;
    logic [31:0] gap;
    ev     = EVT_NONE;
    taken  = 1'b0;
    min16  = longint'($signed(regs.ready_min_g)) * 16;
    diff16 = longint'(regs.disturb_diff_g) * 16;
    thr    = $signed(regs.load_threshold_g);
    case (op)
      OP_UPDATE: begin
        gap = now - last_tick;
        if (gap >= regs.sample_interval_ms) begin
          taken = 1'b1;
          last_tick = now;
          avg = push_average(w);
          diff = avg - prev_avg;
          if (diff < 0) diff = -diff;
          if (latched) begin
            if (timed_out(now)) begin
              drop_latch(avg);
              ev = EVT_WAITING;
            end else if (avg < min16 || diff >= diff16) begin
              if (dist_run < regs.disturb_limit) dist_run++;
              if (dist_run >= regs.disturb_limit) begin
                drop_latch(avg);
                ev = EVT_WAITING;
              end
            end else begin
              dist_run = 0;
            end
            prev_avg = avg;
          end else begin
            if (int'(w) > thr) begin
              if (!hold_on) begin
                hold_on = 1'b1;
                hold_tick = now;
              end
              gap = now - hold_tick;
              if (gap >= regs.hold_time_ms) begin
                latched = 1'b1;
                since_tick = now;
                dist_run = 0;
                announced = 1'b0;
              end
            end else begin
              drop_latch(avg);
              ev = EVT_WAITING;
            end
            prev_avg = avg;
            if (latched && !announced) begin
              announced = 1'b1;
              ev = EVT_READY;
            end
          end
        end
      end
      OP_QUERY: begin
        if (timed_out(now)) begin
          drop_latch(prev_avg);
          ev = EVT_WAITING;
        end
      end
      OP_CLEAR: restore_state();
      default: ;
    endcase
    res.ready_res       = latched;
    res.sample_taken    = taken;
    res.indicator_event = ev;
    res.average_q4      = prev_avg[AVG_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs = '{16'd50, 32'd1000, 32'd30000, 24'sd100, 24'sd50, 23'd20, 8'd3};
      restore_state();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_write(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(qualify_item(in_ch.operation, in_ch.now_ms, in_ch.mass_g));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.ready_res, out_ch.sample_taken, out_ch.indicator_event,
               out_ch.average_q4};
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item outstanding, got ready=%0d taken=%0d event=%0d avg=%0d",
                   $time, got.ready_res, got.sample_taken, got.indicator_event,
                   $signed(got.average_q4));
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected ready=%0d taken=%0d event=%0d avg=%0d",
                     $time, want.ready_res, want.sample_taken, want.indicator_event,
                     $signed(want.average_q4));
            $display("%0t:           actual ready=%0d taken=%0d event=%0d avg=%0d",
                     $time, got.ready_res, got.sample_taken, got.indicator_event,
                     $signed(got.average_q4));
            fail_count++;
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// File: dv/tb_load_ready_qualifier.sv
// Top of the load ready qualifier testbench: clock, reset, register writes, input
// items with bursty timing, a stalling result receiver and the final verdict.
// Depends on lrq_pkg, lrq_if.sv, the block itself and lrq_checker.
module tb_load_ready_qualifier;
  timeunit 1ns;
  timeprecision 1ps;
  import lrq_pkg::*;

  localparam logic [1:0]           OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam logic signed [23:0]   MAX_W       = 24'sh7FFFFF;
  localparam logic signed [23:0]   MIN_W       = 24'sh800000;
  localparam int                   STALL_LIMIT = 4000;
  localparam int                   PHASES      = 12;
  localparam int                   PHASE_ITEMS = 90;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  lrq_in_if  in_ch ();
  lrq_out_if out_ch ();
  lrq_cfg_if cfg_ch ();

  load_ready_qualifier u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lrq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic       rx_ready = 1'b1;
  logic [7:0] rx_phase = 8'd0;
  int         rx_mode  = 0;

  assign out_ch.ready = rx_ready;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase == 8'hFF) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= 1'($urandom_range(0, 1));
      2: rx_ready <= (rx_phase[2:0] != 3'd0) && (rx_phase[2:0] != 3'd5);
      default: rx_ready <= (rx_phase[5:4] != 2'd0);
    endcase
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  cfg_t        cur_cfg;
  logic [31:0] tick;
  int          burst_left = 0;

  function automatic logic signed [23:0] sat24(int v);
    if (v > 8388607) return MAX_W;
    if (v < -8388608) return MIN_W;
    return v[23:0];
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    cur_cfg = c;
    write_reg(REG_SAMPLE_INTERVAL, {16'h0000, c.sample_interval_ms});
    write_reg(REG_HOLD_TIME, c.hold_time_ms);
    write_reg(REG_READY_TIMEOUT, c.ready_timeout_ms);
    write_reg(REG_LOAD_THRESHOLD, {{8{c.load_threshold_g[23]}}, c.load_threshold_g});
    write_reg(REG_READY_MIN, {{8{c.ready_min_g[23]}}, c.ready_min_g});
    write_reg(REG_DISTURB_DIFF, {9'h000, c.disturb_diff_g});
    write_reg(REG_DISTURB_LIMIT, {24'h000000, c.disturb_limit});
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] now, logic signed [23:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_ms    <= now;
    in_ch.mass_g    <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic cfg_t pick_settings();
    cfg_t c;
    int   thr;
    if ($urandom_range(0, 9) == 0) begin
      c.sample_interval_ms = 16'($urandom);
      c.hold_time_ms       = $urandom;
      c.ready_timeout_ms   = $urandom;
      c.load_threshold_g   = 24'($urandom);
      c.ready_min_g        = 24'($urandom);
      c.disturb_diff_g     = 23'($urandom);
      c.disturb_limit      = 8'($urandom);
    end else begin
      thr = int'($urandom_range(0, 4000)) - 2000;
      c.sample_interval_ms = 16'($urandom_range(0, 6));
      c.hold_time_ms       = $urandom_range(0, 40);
      c.ready_timeout_ms   = $urandom_range(0, 300);
      c.load_threshold_g   = sat24(thr);
      c.ready_min_g        = sat24(thr - int'($urandom_range(0, 1500)));
      c.disturb_diff_g     = 23'($urandom_range(0, 2500));
      c.disturb_limit      = 8'($urandom_range(0, 5));
    end
    return c;
  endfunction

  task automatic run_phase(int n_items);
    int          r;
    int          thr;
    int          low;
    logic [31:0] ivl;
    for (int i = 0; i < n_items; i++) begin
      thr = $signed(cur_cfg.load_threshold_g);
      low = $signed(cur_cfg.ready_min_g);
      if (thr < low) low = thr;
      ivl = cur_cfg.sample_interval_ms;
      r = $urandom_range(0, 99);
      if (r < 58) begin
        tick = tick + ivl + $urandom_range(0, 3);
        send_item(OP_UPDATE, tick, sat24(thr + int'($urandom_range(1, 400))));
      end else if (r < 68) begin
        tick = tick + ivl + $urandom_range(0, 3);
        send_item(OP_UPDATE, tick, sat24(low - int'($urandom_range(0, 400))));
      end else if (r < 76) begin
        tick = tick + ivl + $urandom_range(0, 3);
        send_item(OP_UPDATE, tick, sat24(thr + int'($urandom_range(1, 40000))));
      end else if (r < 83) begin
        tick = tick + $urandom_range(0, 300);
        send_item(OP_QUERY, tick, 24'($urandom));
      end else if (r < 88) begin
        tick = tick + ((ivl > 0) ? $urandom_range(0, ivl - 1) : 0);
        send_item(OP_UPDATE, tick, sat24(thr + int'($urandom_range(1, 400))));
      end else if (r < 91) begin
        send_item(OP_UNUSED, $urandom, 24'($urandom));
      end else if (r < 93) begin
        send_item(OP_CLEAR, tick, 24'($urandom));
      end else begin
        tick = $urandom;
        send_item(2'($urandom_range(0, 3)), tick, 24'($urandom));
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_UPDATE;
    in_ch.now_ms    <= '0;
    in_ch.mass_g    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_SAMPLE_INTERVAL;
    cfg_ch.data     <= '0;
    cur_cfg = '{16'd50, 32'd1000, 32'd30000, 24'sd100, 24'sd50, 23'd20, 8'd3};
    tick = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: ignored update, latch, disturbance run, expiry, tick wrap.
    send_item(OP_UNUSED, 32'd123, -24'sd1);
    send_item(OP_QUERY, 32'd0, 24'sd0);
    send_item(OP_UPDATE, 32'd10, MAX_W);
    send_item(OP_UPDATE, 32'd60, MAX_W);
    send_item(OP_UPDATE, 32'd1060, MAX_W);
    send_item(OP_UPDATE, 32'd1110, MAX_W);
    send_item(OP_UPDATE, 32'd1160, MIN_W);
    send_item(OP_UPDATE, 32'd1210, MIN_W);
    send_item(OP_UPDATE, 32'd1260, MIN_W);
    send_item(OP_UPDATE, 32'd1310, 24'sd0);
    send_item(OP_UPDATE, 32'd1360, 24'sd200);
    send_item(OP_UPDATE, 32'd2360, 24'sd200);
    send_item(OP_QUERY, 32'd32359, 24'sd0);
    send_item(OP_QUERY, 32'd32360, 24'sd0);
    send_item(OP_CLEAR, 32'd0, MAX_W);
    send_item(OP_UPDATE, 32'hFFFF_FFF0, 24'sd500);
    send_item(OP_UPDATE, 32'h0000_03E0, 24'sd500);
    send_item(OP_UPDATE, 32'h0000_03E0 + 32'd30000, 24'sd500);
    drain();

    // Extremes of every register; the unused index must change nothing.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    apply_cfg('{16'hFFFF, 32'hFFFF_FFFF, 32'd0, MAX_W, MIN_W, 23'h7FFFFF, 8'hFF});
    send_item(OP_CLEAR, 32'd0, 24'sd0);
    send_item(OP_UPDATE, 32'd65535, MAX_W);
    send_item(OP_UPDATE, 32'd131069, MAX_W);
    send_item(OP_UPDATE, 32'd131070, MIN_W);
    send_item(OP_QUERY, 32'hFFFF_FFFF, MIN_W);
    drain();

    // Immediate latch with a zero disturbance limit.
    apply_cfg('{16'd0, 32'd0, 32'hFFFF_FFFF, MIN_W, MAX_W, 23'd0, 8'd0});
    send_item(OP_CLEAR, 32'd0, 24'sd0);
    send_item(OP_UPDATE, 32'd5, MAX_W);
    send_item(OP_UPDATE, 32'd5, -24'sd8388607);
    send_item(OP_UPDATE, 32'd6, MAX_W);
    send_item(OP_QUERY, 32'hFFFF_FFFE, 24'sd0);
    drain();

    // Zero timeout: ready expires on the next update or query.
    apply_cfg('{16'd0, 32'd0, 32'd0, MIN_W, MIN_W, 23'h7FFFFF, 8'd255});
    send_item(OP_CLEAR, 32'd0, 24'sd0);
    send_item(OP_UPDATE, 32'd1, 24'sd0);
    send_item(OP_UPDATE, 32'd1, 24'sd0);
    send_item(OP_UPDATE, 32'd2, 24'sd100);
    send_item(OP_QUERY, 32'd2, 24'sd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      apply_cfg(pick_settings());
      tick = $urandom;
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
